@@ hw/rtl/dlfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfe_pkg
// Shared widths, constants, command codes and control structs of the dimmer
// level fade engine.
// ----------------------------------------------------------------------------
package dlfe_pkg;

  localparam int LEVEL_W    = 8;
  localparam int TIME_W     = 23;
  localparam int IV_W       = 16;
  localparam int TENTHS_W   = 16;
  localparam int KIND_W     = 3;
  localparam int DIV_CNT_W  = $clog2(TIME_W + 1);
  localparam int SECS_W     = LEVEL_W + 1;
  localparam int MS_W       = 10;
  localparam int TENTH_MS_W = 7;
  localparam int MOVE_MS_W  = SECS_W + MS_W;

  localparam logic [LEVEL_W-1:0]    LEVEL_MAX    = 8'hFF;
  localparam logic [LEVEL_W-1:0]    LEVEL_RESET  = 8'd1;
  localparam logic [IV_W-1:0]       IV_MAX       = 16'hFFFF;
  localparam logic [IV_W-1:0]       IV_SECOND    = 16'd1000;
  localparam logic [TENTH_MS_W-1:0] MS_PER_TENTH = 7'd100;
  localparam logic [MS_W-1:0]       MS_PER_S     = 10'd1000;

  // command kinds carried by an input beat
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK    = 3'd0,
    KIND_MOVE_TO = 3'd1,
    KIND_MOVE    = 3'd2,
    KIND_STEP    = 3'd3,
    KIND_STOP    = 3'd4,
    KIND_SET     = 3'd5
  } kind_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TICK,
    OP_LAND,
    OP_MOVE_LEVEL,
    OP_GOAL_TARGET,
    OP_GOAL_STEP,
    OP_PLAN_SETUP,
    OP_PLAN_END,
    OP_MOVE_SETUP,
    OP_MOVE_END,
    OP_STOP,
    OP_SET,
    OP_REJECT,
    OP_RESULT
  } op_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              active;
    logic              time_zero;
    logic              iv_zero;
    logic              plan_land;
    logic              move_div;
    logic              div_busy;
  } dp_status_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LEVEL_W-1:0]  target_level;
    logic                direction;
    logic [LEVEL_W-1:0]  amount;
    logic [TENTHS_W-1:0] transition_tenths;
  } cmd_fields_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               moving;
    logic               status;
  } rsp_fields_t;

endpackage

@@ hw/rtl/dlfe_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfe_in_if
// Command channel: valid/ready handshake with one command per beat.
// ----------------------------------------------------------------------------
interface dlfe_in_if import dlfe_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [LEVEL_W-1:0]  target_level;
  logic                direction;
  logic [LEVEL_W-1:0]  amount;
  logic [TENTHS_W-1:0] transition_tenths;

  modport source (
    output valid, kind, target_level, direction, amount, transition_tenths,
    input  ready
  );

  modport sink (
    input  valid, kind, target_level, direction, amount, transition_tenths,
    output ready
  );

endinterface

@@ hw/rtl/dlfe_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfe_out_if
// Result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface dlfe_out_if import dlfe_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               moving;
  logic               status;

  modport source (
    output valid, level, moving, status,
    input  ready
  );

  modport sink (
    input  valid, level, moving, status,
    output ready
  );

endinterface

@@ hw/rtl/dlfe_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfe_div
// Restoring divider, one quotient bit per cycle, 23-bit dividend over an
// 8-bit divisor.
// ----------------------------------------------------------------------------
module dlfe_div import dlfe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [TIME_W-1:0]  dividend,
  input  logic [LEVEL_W-1:0] divisor,
  output logic               busy,
  output logic [TIME_W-1:0]  quotient
);

  logic [TIME_W-1:0]    quo;
  logic [LEVEL_W-1:0]   rem;
  logic [LEVEL_W-1:0]   dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [LEVEL_W:0]     trial;
  logic [LEVEL_W:0]     diff;
  logic                 fits;

  assign trial    = {rem, quo[TIME_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign diff     = trial - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(TIME_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[TIME_W-2:0], fits};
      rem <= fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
    end
  end

endmodule

@@ hw/rtl/dlfe_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfe_dpath
// Fade datapath: level and transition registers, planning arithmetic,
// shared divider and result register.
// ----------------------------------------------------------------------------
module dlfe_dpath import dlfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  op_t         op,
  input  cmd_fields_t fields,
  output rsp_fields_t rsp_data,
  output dp_status_t  st
);

  // captured command
  logic [KIND_W-1:0]  kind_q;
  logic [LEVEL_W-1:0] target_q;
  logic               dir_q;
  logic [LEVEL_W-1:0] amount_q;
  logic               status_q;

  // fade state
  logic [LEVEL_W-1:0] current_level;
  logic [LEVEL_W-1:0] goal_level;
  logic               going_down;
  logic [LEVEL_W-1:0] stride;
  logic [TIME_W-1:0]  time_left;
  logic [IV_W-1:0]    interval_left;
  logic               active;

  // planning
  logic [TIME_W-1:0]  plan_t;
  logic               plan_long;

  logic [LEVEL_W-1:0]   gap;
  logic                 goal_above;
  logic                 plan_long_c;
  logic [LEVEL_W:0]     step_sum;
  logic [LEVEL_W-1:0]   step_goal;
  logic [LEVEL_W-1:0]   move_goal;
  logic [LEVEL_W-1:0]   move_span;
  logic [LEVEL_W:0]     stride_sum;
  logic [LEVEL_W-1:0]   level_moved;
  logic [TIME_W-1:0]    time_dec;
  logic [IV_W-1:0]      iv_dec;
  logic [TIME_W-1:0]    plan_ms;
  logic [SECS_W-1:0]    move_secs;
  logic [MOVE_MS_W-1:0] move_ms;
  logic [IV_W-1:0]      iv_sat;
  logic                 move_div;
  logic                 div_start;
  logic [TIME_W-1:0]    div_dividend;
  logic [LEVEL_W-1:0]   div_divisor;
  logic                 div_busy;
  logic [TIME_W-1:0]    quo;

  assign goal_above  = goal_level > current_level;
  assign gap         = goal_above ? goal_level - current_level : current_level - goal_level;
  assign plan_long_c = plan_t > TIME_W'(gap);

  assign step_sum  = {1'b0, current_level} + {1'b0, amount_q};
  assign step_goal = dir_q ? ((amount_q > current_level) ? '0 : current_level - amount_q)
                           : (step_sum[LEVEL_W] ? LEVEL_MAX : step_sum[LEVEL_W-1:0]);

  assign move_goal = dir_q ? '0 : LEVEL_MAX;
  assign move_span = dir_q ? current_level : LEVEL_MAX - current_level;
  assign move_div  = (amount_q != '0) && (amount_q != LEVEL_MAX);

  assign stride_sum  = {1'b0, current_level} + {1'b0, stride};
  assign level_moved = going_down ? ((stride > current_level) ? '0 : current_level - stride)
                                  : (stride_sum[LEVEL_W] ? LEVEL_MAX
                                                         : stride_sum[LEVEL_W-1:0]);

  assign time_dec = (time_left != '0) ? time_left - TIME_W'(1) : time_left;
  assign iv_dec   = (interval_left != '0) ? interval_left - IV_W'(1) : interval_left;

  assign plan_ms   = {{(TIME_W-TENTHS_W){1'b0}}, fields.transition_tenths}
                   * {{(TIME_W-TENTH_MS_W){1'b0}}, MS_PER_TENTH};
  assign move_secs = {1'b0, quo[LEVEL_W-1:0]} + SECS_W'(1);
  assign move_ms   = {{MS_W{1'b0}}, move_secs} * {{SECS_W{1'b0}}, MS_PER_S};
  assign iv_sat    = (quo > TIME_W'(IV_MAX)) ? IV_MAX : quo[IV_W-1:0];

  // divider operands: move span over rate, or time over distance either way round
  always_comb begin
    if (op == OP_MOVE_SETUP) begin
      div_dividend = TIME_W'(move_span);
      div_divisor  = amount_q;
    end else if (plan_long_c) begin
      div_dividend = plan_t;
      div_divisor  = gap;
    end else begin
      div_dividend = TIME_W'(gap);
      div_divisor  = plan_t[LEVEL_W-1:0];
    end
  end

  assign div_start = ((op == OP_PLAN_SETUP) && (gap != '0) && (plan_t != '0))
                   || ((op == OP_MOVE_SETUP) && move_div);

  dlfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= LEVEL_RESET;
      goal_level    <= '0;
      going_down    <= 1'b0;
      stride        <= '0;
      time_left     <= '0;
      interval_left <= '0;
      active        <= 1'b0;
    end else begin
      unique case (op)
        OP_TICK: begin
          time_left     <= time_dec;
          interval_left <= iv_dec;
        end
        OP_LAND: begin
          current_level <= goal_level;
          active        <= 1'b0;
          time_left     <= '0;
          interval_left <= '0;
        end
        OP_MOVE_LEVEL:  current_level <= level_moved;
        OP_GOAL_TARGET: goal_level <= target_q;
        OP_GOAL_STEP:   goal_level <= step_goal;
        OP_PLAN_SETUP: begin
          going_down <= !goal_above;
          if ((gap == '0) || (plan_t == '0)) begin
            current_level <= goal_level;
            active        <= 1'b0;
            time_left     <= '0;
            interval_left <= '0;
          end else begin
            active    <= 1'b1;
            time_left <= plan_t;
          end
        end
        OP_PLAN_END: begin
          if (plan_long) begin
            stride        <= LEVEL_W'(1);
            interval_left <= iv_sat;
          end else begin
            stride        <= quo[LEVEL_W-1:0];
            interval_left <= IV_W'(1);
          end
        end
        OP_MOVE_SETUP: begin
          going_down <= dir_q;
          goal_level <= move_goal;
          if (amount_q == LEVEL_MAX) begin
            // full rate jumps straight to the end stop
            current_level <= move_goal;
            active        <= 1'b0;
            time_left     <= '0;
            interval_left <= '0;
          end else if (amount_q == '0) begin
            active <= 1'b0;
          end else begin
            stride        <= amount_q;
            interval_left <= IV_SECOND;
            active        <= 1'b1;
          end
        end
        OP_MOVE_END: time_left <= TIME_W'(move_ms);
        OP_STOP:     active <= 1'b0;
        OP_SET: begin
          current_level <= target_q;
          active        <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      kind_q   <= fields.kind;
      target_q <= fields.target_level;
      dir_q    <= fields.direction;
      amount_q <= fields.amount;
      status_q <= 1'b0;
      plan_t   <= plan_ms;
    end
    if (op == OP_TICK) begin
      plan_t <= time_dec;
    end
    if (op == OP_REJECT) begin
      status_q <= 1'b1;
    end
    if (op == OP_PLAN_SETUP) begin
      plan_long <= plan_long_c;
    end
    if (op == OP_RESULT) begin
      rsp_data.level  <= current_level;
      rsp_data.moving <= active;
      rsp_data.status <= status_q;
    end
  end

  assign st.kind      = kind_q;
  assign st.active    = active;
  assign st.time_zero = time_left == '0;
  assign st.iv_zero   = interval_left == '0;
  assign st.plan_land = (gap == '0) || (plan_t == '0);
  assign st.move_div  = move_div;
  assign st.div_busy  = div_busy;

endmodule

@@ hw/rtl/dlfe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfe_ctrl
// Fade controller: sequences one command through the datapath and holds
// the result valid flag.
// ----------------------------------------------------------------------------
module dlfe_ctrl import dlfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output logic       in_ready,
  output logic       out_valid,
  output op_t        op
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_TICK   = 6'b000100,
    S_PLAN   = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   div_move;
  logic   div_move_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    op            = OP_NONE;
    state_next    = state;
    div_move_next = div_move;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.kind)
          KIND_TICK: begin
            if (st.active) begin
              op         = OP_TICK;
              state_next = S_TICK;
            end else begin
              state_next = S_DONE;
            end
          end
          KIND_MOVE_TO: begin
            op         = OP_GOAL_TARGET;
            state_next = S_PLAN;
          end
          KIND_STEP: begin
            op         = OP_GOAL_STEP;
            state_next = S_PLAN;
          end
          KIND_MOVE: begin
            op            = OP_MOVE_SETUP;
            div_move_next = 1'b1;
            state_next    = st.move_div ? S_DIV : S_DONE;
          end
          KIND_STOP: begin
            op         = OP_STOP;
            state_next = S_DONE;
          end
          KIND_SET: begin
            op         = OP_SET;
            state_next = S_DONE;
          end
          default: begin
            op         = OP_REJECT;
            state_next = S_DONE;
          end
        endcase
      end
      S_TICK: begin
        priority if (st.time_zero) begin
          op         = OP_LAND;
          state_next = S_DONE;
        end else if (st.iv_zero) begin
          op         = OP_MOVE_LEVEL;
          state_next = S_PLAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PLAN: begin
        op            = OP_PLAN_SETUP;
        div_move_next = 1'b0;
        state_next    = st.plan_land ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (!st.div_busy) begin
          op         = div_move ? OP_MOVE_END : OP_PLAN_END;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          op         = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_move  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      div_move <= div_move_next;
      if (op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/dimmer_level_fade_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dimmer_level_fade_engine
// Level control fade engine: takes millisecond ticks and level commands and
// returns the output level, moving flag and status after each command.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     beat payload
//   -------  ---  ------------  ---------------------------------------------
//   cmd      in   valid/ready   kind, target_level, direction, amount,
//                               transition_tenths
//   rsp      out  valid/ready   level, moving, status
//
// one command at a time; a beat is taken only while the controller is idle
// simple commands (stop, set, idle tick, reject) go straight to the result;
// a tick that only counts down, or a plan that lands at once, skips the divider;
// commands that replan (move to level, step, move, interval tick) otherwise
// wait on the bit-serial divider shared by all of them
// the result register frees the command side: a new beat is taken while the
// previous result still waits on rsp.ready
// rst is synchronous; after it the level is 1 and no transition runs
//
module dimmer_level_fade_engine import dlfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dlfe_in_if.sink    cmd,
  dlfe_out_if.source rsp
);

  op_t         op;
  dp_status_t  st;
  cmd_fields_t fields;
  rsp_fields_t rsp_data;
  logic        in_ready;
  logic        out_valid;

  // gather the command beat into one struct for the datapath
  assign fields.kind              = cmd.kind;
  assign fields.target_level      = cmd.target_level;
  assign fields.direction         = cmd.direction;
  assign fields.amount            = cmd.amount;
  assign fields.transition_tenths = cmd.transition_tenths;

  assign cmd.ready  = in_ready;
  assign rsp.valid  = out_valid;
  assign rsp.level  = rsp_data.level;
  assign rsp.moving = rsp_data.moving;
  assign rsp.status = rsp_data.status;

  // controller: decodes the command and steps the datapath
  dlfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .op        (op)
  );

  // datapath: fade state, planning arithmetic and divider
  dlfe_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .fields   (fields),
    .rsp_data (rsp_data),
    .st       (st)
  );

  // a running transition always has time left once a command is finished
  a_active_has_time: assert property (@(posedge clk) disable iff (rst)
    (cmd.ready && st.active) |-> !st.time_zero)
    else $error("transition active with no time left");

  // a new result never overwrites one that has not been taken
  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    (op == OP_RESULT) |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten");

  // the divider is idle whenever a plan is set up
  a_div_idle_at_plan: assert property (@(posedge clk) disable iff (rst)
    (op == OP_PLAN_SETUP || op == OP_MOVE_SETUP) |-> !st.div_busy)
    else $error("divider restarted while busy");

  // result valid only rises after a result load
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(op == OP_RESULT))
    else $error("result valid without a load");

endmodule
